[hw/rtl/evm_word_alu_256_unit_macros.svh]
// Assertion macros for the 256-bit word ALU checker.
// Used by the checker only.
`ifndef EVM_WORD_ALU_256_UNIT_MACROS_SVH
`define EVM_WORD_ALU_256_UNIT_MACROS_SVH
// property that must hold every cycle out of reset
`define EWA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// non-overlapping implication
`define EWA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`endif

[hw/rtl/ewa_pkg.sv]
// Package for the 256-bit word ALU: op codes and the queued word type.
// No dependencies.
package ewa_pkg;
	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_LT = 5'd2, OP_GT = 5'd3, OP_SLT = 5'd4,
		OP_SGT = 5'd5, OP_EQ = 5'd6, OP_EQZ = 5'd7, OP_AND = 5'd8, OP_OR = 5'd9,
		OP_XOR = 5'd10, OP_NOT = 5'd11, OP_BYTE = 5'd12, OP_SHL = 5'd13,
		OP_SHR = 5'd14, OP_SAR = 5'd15, OP_SIGNEXT = 5'd16
	} op_t;

	// classified word passed from front to back
	typedef struct packed {
		logic [4:0]   cmd;
		logic         small256;  // A < 256
		logic         small32;   // A < 32
		logic         small31;   // A < 31
		logic [255:0] a;
		logic [255:0] b;
	} ewa_item_t;
endpackage

[hw/rtl/evm_word_alu_256_unit.sv]
// Top level of the 256-bit word ALU: front, queue, back.
// Depends on ewa_pkg, ewa_front, ewa_queue, ewa_back.
//
// Stateless 256-bit ALU for a stack machine. One word is accepted per clock
// when the output side keeps up; each result passes the front register, a
// queue entry and the back result register before it is valid on the
// outputs. The back stage evaluates any operation combinationally, so
// throughput is one word per cycle when the output keeps up. The two-entry
// queue lets the front take words while the output stalls, until it fills.
module evm_word_alu_256_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  cmd,
	input  logic [63:0] top_limb3,
	input  logic [63:0] top_limb2,
	input  logic [63:0] top_limb1,
	input  logic [63:0] top_limb0,
	input  logic [63:0] second_limb3,
	input  logic [63:0] second_limb2,
	input  logic [63:0] second_limb1,
	input  logic [63:0] second_limb0,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] res_limb3,
	output logic [63:0] res_limb2,
	output logic [63:0] res_limb1,
	output logic [63:0] res_limb0
);
	ewa_pkg::ewa_item_t in_item, fq_item, qb_item;
	logic               fq_valid, fq_stall, qb_valid, qb_stall;
	logic [255:0]       res;

	always_comb begin
		in_item = '0;
		in_item.cmd = cmd;
		in_item.a = {top_limb3, top_limb2, top_limb1, top_limb0};
		in_item.b = {second_limb3, second_limb2, second_limb1, second_limb0};
	end

	ewa_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.out_valid(fq_valid), .out_stall(fq_stall), .out_item(fq_item)
	);

	ewa_queue u_queue (
		.clk, .arst_n, .in_valid(fq_valid), .in_stall(fq_stall), .in_item(fq_item),
		.out_valid(qb_valid), .out_stall(qb_stall), .out_item(qb_item)
	);

	ewa_back u_back (
		.clk, .arst_n, .in_valid(qb_valid), .in_stall(qb_stall), .in_item(qb_item),
		.out_valid, .out_stall, .out_res(res)
	);

	assign {res_limb3, res_limb2, res_limb1, res_limb0} = res;
endmodule

[hw/rtl/ewa_front.sv]
// Front: registers incoming words and classifies the range of operand A.
// Depends on ewa_pkg.
module ewa_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ewa_pkg::ewa_item_t in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output ewa_pkg::ewa_item_t out_item
);
	logic               valid_q;
	ewa_pkg::ewa_item_t item_q;
	logic               hi_zero;
	ewa_pkg::ewa_item_t cls;

	assign in_stall = valid_q && out_stall;
	assign hi_zero = (in_item.a[255:64] == '0);

	always_comb begin
		cls = in_item;
		cls.small256 = hi_zero && (in_item.a[63:8] == '0);
		cls.small32 = hi_zero && (in_item.a[63:5] == '0);
		cls.small31 = cls.small32 && (in_item.a[4:0] != 5'd31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_q <= cls;
		end
	end

	assign out_valid = valid_q;
	assign out_item = item_q;
endmodule

[hw/rtl/ewa_queue.sv]
// Two-entry queue between front and back.
// Depends on ewa_pkg.
module ewa_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ewa_pkg::ewa_item_t in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output ewa_pkg::ewa_item_t out_item
);
	ewa_pkg::ewa_item_t mem_q [2];
	logic               wp_q;
	logic               rp_q;
	logic [1:0]         cnt_q;
	logic               push;
	logic               pop;

	assign in_stall = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;
	assign out_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end
endmodule

[hw/rtl/ewa_back.sv]
// Back: executes one word per cycle, when the output is not stalled, into an output register.
// Depends on ewa_pkg.
module ewa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ewa_pkg::ewa_item_t in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [255:0]       out_res
);
	logic         valid_q;
	logic [255:0] res_q;
	logic [255:0] a, b, r;
	logic [256:0] sum, dif;
	logic         ult, ugt, slt, sgt, eq;
	logic [7:0]   sh;
	logic [4:0]   pos;
	logic [7:0]   tb;
	logic [255:0] keep;
	logic         sgn;
	logic [255:0] sra;

	assign in_stall = valid_q && out_stall;
	assign a = in_item.a;
	assign b = in_item.b;
	assign sh = a[7:0];

	always_comb begin
		sum = {1'b0, a} + {1'b0, b};
		dif = {1'b0, a} - {1'b0, b};
		ult = dif[256];
		eq = (a == b);
		ugt = !ult && !eq;
		// signs differ: negative one is smaller
		slt = (a[255] != b[255]) ? a[255] : ult;
		sgt = !slt && !eq;
		pos = 5'd31 - a[4:0];
		tb = {a[4:0], 3'b111};
		keep = {255'b0, 1'b1} << tb;
		keep = (keep << 1) - 256'd1;
		keep = (tb == 8'd255) ? '1 : keep;
		sgn = b[tb];
		sra = $signed(b) >>> sh;
		r = '0;
		case (ewa_pkg::op_t'(in_item.cmd))
			ewa_pkg::OP_ADD:    r = sum[255:0];
			ewa_pkg::OP_SUB:    r = dif[255:0];
			ewa_pkg::OP_LT:     r = {255'b0, ult};
			ewa_pkg::OP_GT:     r = {255'b0, ugt};
			ewa_pkg::OP_SLT:    r = {255'b0, slt};
			ewa_pkg::OP_SGT:    r = {255'b0, sgt};
			ewa_pkg::OP_EQ:     r = {255'b0, eq};
			ewa_pkg::OP_EQZ:    r = {255'b0, (a == '0)};
			ewa_pkg::OP_AND:    r = a & b;
			ewa_pkg::OP_OR:     r = a | b;
			ewa_pkg::OP_XOR:    r = a ^ b;
			ewa_pkg::OP_NOT:    r = ~a;
			ewa_pkg::OP_BYTE:
				if (in_item.small32) r = {248'b0, b[{pos, 3'b000} +: 8]};
			ewa_pkg::OP_SHL:
				if (in_item.small256) r = b << sh;
			ewa_pkg::OP_SHR:
				if (in_item.small256) r = b >> sh;
			ewa_pkg::OP_SAR:
				r = in_item.small256 ? sra : {256{b[255]}};
			ewa_pkg::OP_SIGNEXT:
				r = !in_item.small31 ? b : (sgn ? (b | ~keep) : (b & keep));
			default: r = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			res_q <= r;
		end
	end

	assign out_valid = valid_q;
	assign out_res = res_q;
endmodule

[hw/rtl/ewa_checker.sv]
// Port-level checker for the 256-bit word ALU, bound to the top level.
// Depends on evm_word_alu_256_unit_macros.svh.
`include "evm_word_alu_256_unit_macros.svh"
module ewa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] res_limb0
);
	`EWA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res_limb0), "stalled word changed")
	`EWA_ASSERT(a_in_stall_cause, !in_stall || out_valid, "input stalled with no word pending")
	`EWA_ASSERT_NEXT(a_free_flow, !out_stall && !in_stall, !in_stall, "input stalled without output stall")
endmodule

bind evm_word_alu_256_unit ewa_checker u_ewa_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .res_limb0
);
